// File: sv/assert_macros.svh
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dar_pkg.sv
package dar_pkg;

  // Sizes of the allow list and of the queue between front and back.
  localparam int MAX_ENTRIES     = 4;
  localparam int ENTRIES_DEF     = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Field widths.
  localparam int WINDOW_W  = 31;
  localparam int THRESH_W  = 8;
  localparam int ENTRY_W   = 33;
  localparam int ID_W      = 16;
  localparam int KEY_W     = 32;
  localparam int TS_W      = 32;
  localparam int CNT_W     = 8;
  localparam int IDX_W     = 2;
  localparam int CFG_IDX_W = 3;

  localparam int ENTRY_VALID_BIT = 32;

  localparam logic [CNT_W-1:0]    COUNT_MAX    = 8'hFF;
  localparam logic [CNT_W-1:0]    COUNT_FIRST  = 8'd1;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 31'd60000;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd5;

  // Reset contents of the allow entries; the last one starts invalid.
  localparam logic [MAX_ENTRIES-1:0][ENTRY_W-1:0] ENTRY_RESET = {
    33'h0_0000_0000, 33'h1_325D_6310, 33'h1_058F_6387, 33'h1_0781_5591
  };

  // Event kinds.
  localparam logic FUNC_ATTACH = 1'b0;
  localparam logic FUNC_DETACH = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 3'd0,
    CFG_THRESH = 3'd1,
    CFG_ENTRY0 = 3'd2,
    CFG_ENTRY1 = 3'd3,
    CFG_ENTRY2 = 3'd4,
    CFG_ENTRY3 = 3'd5
  } cfg_idx_t;

  // Live configuration.
  typedef struct packed {
    logic [WINDOW_W-1:0]                 window;
    logic [THRESH_W-1:0]                 thresh;
    logic [MAX_ENTRIES-1:0][ENTRY_W-1:0] entry;
  } dar_cfg_t;

  // Classified event handed from the front to the back.
  typedef struct packed {
    logic             func;
    logic             matched;
    logic [IDX_W-1:0] idx;
    logic [TS_W-1:0]  timestamp;
  } dar_job_t;

  // Back sequencer states.
  typedef enum logic [1:0] {
    B_IDLE,
    B_CALC,
    B_WRITE
  } back_state_t;

endpackage

// File: sv/dar_in_if.sv
interface dar_in_if;
  import dar_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [ID_W-1:0]     vendor_id;
  logic [ID_W-1:0]     product_id;
  logic [TS_W-1:0]     timestamp;

  modport source (output valid, func, vendor_id, product_id, timestamp, input ready);
  modport sink (input valid, func, vendor_id, product_id, timestamp, output ready);
endinterface

// File: sv/dar_out_if.sv
interface dar_out_if;
  import dar_pkg::*;

  logic              valid;
  logic              ready;
  logic              matched;
  logic [IDX_W-1:0]  match_index;
  logic              verdict;
  logic              revoked_now;
  logic [CNT_W-1:0]  window_count;

  modport source (output valid, matched, match_index, verdict, revoked_now, window_count,
                  input ready);
  modport sink (input valid, matched, match_index, verdict, revoked_now, window_count,
                output ready);
endinterface

// File: sv/dar_cfg_if.sv
interface dar_cfg_if;
  import dar_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ENTRY_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/dar_regs.sv
module dar_regs (
  input  logic              clk,
  input  logic              rst_n,
  dar_cfg_if.sink           cfg_ch,
  output dar_pkg::dar_cfg_t cfg
);
  import dar_pkg::*;

  logic [WINDOW_W-1:0]                 window_r;
  logic [THRESH_W-1:0]                 thresh_r;
  logic [MAX_ENTRIES-1:0][ENTRY_W-1:0] entry_r;
  logic                                wr_en;

  // The register file takes a word every cycle.
  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;

  // Register write decode; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      thresh_r <= THRESH_RESET;
      entry_r  <= ENTRY_RESET;
    end else if (wr_en) begin
      unique case (cfg_ch.index)
        CFG_WINDOW: window_r   <= cfg_ch.data[WINDOW_W-1:0];
        CFG_THRESH: thresh_r   <= cfg_ch.data[THRESH_W-1:0];
        CFG_ENTRY0: entry_r[0] <= cfg_ch.data;
        CFG_ENTRY1: entry_r[1] <= cfg_ch.data;
        CFG_ENTRY2: entry_r[2] <= cfg_ch.data;
        CFG_ENTRY3: entry_r[3] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cfg.window = window_r;
  assign cfg.thresh = thresh_r;
  assign cfg.entry  = entry_r;
endmodule

// File: sv/dar_front.sv
module dar_front #(
  parameter int ENTRIES = dar_pkg::ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  dar_in_if.sink            in_ch,
  input  dar_pkg::dar_cfg_t cfg,
  input  logic              q_full,
  output logic              q_push,
  output dar_pkg::dar_job_t q_job
);
  import dar_pkg::*;

  logic             hold_valid_r;
  logic             func_r;
  logic [KEY_W-1:0] key_r;
  logic [TS_W-1:0]  ts_r;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;

  // The hold register frees up as soon as its word moves into the queue.
  assign q_push       = hold_valid_r && !q_full;
  assign in_ch.ready  = !hold_valid_r || q_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      hold_valid_r <= in_ch.valid;
    end
  end

  // Event capture.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r <= in_ch.func;
      key_r  <= {in_ch.vendor_id, in_ch.product_id};
      ts_r   <= in_ch.timestamp;
    end
  end

  // Allow-list match; scanning downward leaves the lowest hit in place.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (cfg.entry[i][ENTRY_VALID_BIT] && (cfg.entry[i][KEY_W-1:0] == key_r)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign q_job.func      = func_r;
  assign q_job.matched   = hit;
  assign q_job.idx       = hit_idx;
  assign q_job.timestamp = ts_r;
endmodule

// File: sv/dar_fifo.sv
module dar_fifo #(
  parameter int DEPTH = dar_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dar_pkg::dar_job_t wr_job,
  input  logic              pop,
  output dar_pkg::dar_job_t rd_job,
  output logic              full,
  output logic              empty
);
  import dar_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  dar_job_t             mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [CNT_W_Q-1:0]   count_r;

  assign full   = (count_r == CNT_W_Q'(DEPTH));
  assign empty  = (count_r == '0);
  assign rd_job = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end
endmodule

// File: sv/dar_back.sv
module dar_back #(
  parameter int ENTRIES = dar_pkg::ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dar_pkg::dar_cfg_t cfg,
  input  logic              q_empty,
  input  dar_pkg::dar_job_t q_job,
  output logic              q_pop,
  dar_out_if.source         out_ch
);
  import dar_pkg::*;

  back_state_t      state_r;
  back_state_t      state_nxt;
  dar_job_t         job_r;
  logic             load;

  // Per-entry rate state.
  logic [TS_W-1:0]  last_time_r [ENTRIES];
  logic [CNT_W-1:0] evt_cnt_r   [ENTRIES];
  logic             revoked_r   [ENTRIES];

  // Selected entry, registered in the calc step.
  logic [TS_W-1:0]  cur_last;
  logic [CNT_W-1:0] cur_cnt;
  logic             cur_rev;
  logic [TS_W-1:0]  limit_r;
  logic [CNT_W-1:0] sel_cnt_r;
  logic             sel_rev_r;

  // Update results.
  logic [TS_W-1:0]  diff;
  logic             after;
  logic [CNT_W-1:0] cnt_new;
  logic             rev_hit;
  logic             rev_new;

  // Output register.
  logic             out_valid_r;
  logic             matched_r;
  logic [IDX_W-1:0] idx_r;
  logic             verdict_r;
  logic             rev_now_r;
  logic [CNT_W-1:0] count_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = B_CALC;
      B_CALC:  state_nxt = B_WRITE;
      B_WRITE: begin
        if (load) begin
          state_nxt = q_empty ? B_IDLE : B_CALC;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    load  = (state_r == B_WRITE) && (!out_valid_r || out_ch.ready);
    q_pop = !q_empty && ((state_r == B_IDLE) || load);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Current job.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
  end

  // Pick the matched entry's state.
  always_comb begin
    cur_last = '0;
    cur_cnt  = '0;
    cur_rev  = 1'b0;
    for (int e = 0; e < ENTRIES; e++) begin
      if (job_r.idx == IDX_W'(e)) begin
        cur_last = last_time_r[e];
        cur_cnt  = evt_cnt_r[e];
        cur_rev  = revoked_r[e];
      end
    end
  end

  // Window end for this entry.
  always_ff @(posedge clk) begin
    if (state_r == B_CALC) begin
      limit_r   <= cur_last + TS_W'(cfg.window);
      sel_cnt_r <= cur_cnt;
      sel_rev_r <= cur_rev;
    end
  end

  // Count restart or saturating increment, then the revoke check.
  always_comb begin
    diff    = limit_r - job_r.timestamp;
    after   = diff[TS_W-1];
    if (after) begin
      cnt_new = COUNT_FIRST;
    end else if (sel_cnt_r == COUNT_MAX) begin
      cnt_new = COUNT_MAX;
    end else begin
      cnt_new = sel_cnt_r + 1'b1;
    end
    rev_hit = !sel_rev_r && (cnt_new >= cfg.thresh);
    rev_new = sel_rev_r || rev_hit;
  end

  // State write-back for a matched event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < ENTRIES; e++) begin
        last_time_r[e] <= '0;
        evt_cnt_r[e]   <= '0;
        revoked_r[e]   <= 1'b0;
      end
    end else if (load && job_r.matched) begin
      for (int e = 0; e < ENTRIES; e++) begin
        if (job_r.idx == IDX_W'(e)) begin
          last_time_r[e] <= job_r.timestamp;
          evt_cnt_r[e]   <= cnt_new;
          revoked_r[e]   <= rev_new;
        end
      end
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      matched_r <= job_r.matched;
      idx_r     <= job_r.idx;
      verdict_r <= (job_r.func == FUNC_DETACH) ? 1'b0 : !(job_r.matched && !rev_new);
      rev_now_r <= job_r.matched && rev_hit;
      count_r   <= job_r.matched ? cnt_new : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.matched      = matched_r;
  assign out_ch.match_index  = idx_r;
  assign out_ch.verdict      = verdict_r;
  assign out_ch.revoked_now  = rev_now_r;
  assign out_ch.window_count = count_r;
endmodule

// File: sv/device_allowlist_rate_revoker.sv
// An event passes the front hold register, the queue, the back job register, the calc
// registers and the output register; the back sequencer handles one entry update at
// a time through its calc and write steps, and stalls while the output is not taken.
// Synchronous active-low reset restores the register defaults, clears all per-entry
// counts, times and revoke flags, and empties the queue and the output register.
`include "assert_macros.svh"

module device_allowlist_rate_revoker #(
  parameter int ENTRIES     = dar_pkg::ENTRIES_DEF,
  parameter int QUEUE_DEPTH = dar_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dar_in_if.sink     in_ch,
  dar_out_if.source  out_ch,
  dar_cfg_if.sink    cfg_ch
);
  import dar_pkg::*;

  dar_cfg_t cfg;
  dar_job_t push_job;
  dar_job_t head_job;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  // Configuration registers.
  dar_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Accept and match.
  dar_front #(.ENTRIES(ENTRIES)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  // Queue between classification and update.
  dar_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (push_job),
    .pop    (q_pop),
    .rd_job (head_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  // Rate update and result.
  dar_back #(.ENTRIES(ENTRIES)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_job   (head_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // Queue must never overflow or underflow.
  `ASSERT_NOW(a_no_overflow, clk, rst_n, q_push, !q_full || q_pop, "queue overflow")
  `ASSERT_NOW(a_no_underflow, clk, rst_n, q_pop, !q_empty, "queue underflow")
  // A word taken by the front is pushed into the queue in the next cycle unless the queue is full.
  `ASSERT_NEXT(a_push_after_take, clk, rst_n, in_ch.valid && in_ch.ready && !q_push,
               q_push || q_full, "accepted event lost")
  // An unmatched event carries no count and no revoke.
  `ASSERT_NOW(a_unmatched_clean, clk, rst_n, out_ch.valid && !out_ch.matched,
              out_ch.window_count == '0 && !out_ch.revoked_now, "unmatched result dirty")
endmodule
